// ===== sv/lrbm_pkg.sv =====
// Shared constants and the result record of the label region boundary mask unit.
// No dependencies.
`default_nettype none

package lrbm_pkg;

  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_SIZE_RESET = 2048;
  localparam int POS_W          = 11;
  localparam int IN_COLOR_W     = 32;
  localparam int OUT_DEPTH      = 4;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_COLOR_BITS = 32;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  typedef struct packed {
    logic             is_boundary;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/lrbm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during a write to the same entry returns the old contents. No dependencies.
`default_nettype none

module lrbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrbm_window.sv =====
// 3x3 colour window and the eight-neighbour inequality test on its centre.
// Depends on nothing but its ports.
`default_nettype none

module lrbm_window #(
  parameter int COLOR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic [COLOR_BITS-1:0] up,
  input  wire logic [COLOR_BITS-1:0] lo,
  input  wire logic [COLOR_BITS-1:0] color,
  output      logic                  differs
);

  // rows: 0..2 two rows up, 3..5 one row up, 6..8 current row; centre is 4
  logic [COLOR_BITS-1:0] win [9];

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k]   <= win[3*k+1];
        win[3*k+1] <= win[3*k+2];
      end
      win[2] <= up;
      win[5] <= lo;
      win[8] <= color;
    end
  end

  always_comb begin
    differs = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && win[k] != win[4]) begin
        differs = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrbm_out_fifo.sv =====
// Small result queue between the classifier and the result channel.
// Depends on lrbm_pkg for the result record.
`default_nettype none

module lrbm_out_fifo
  import lrbm_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire res_t                       push_data,
  output      logic                       pop_valid,
  input  wire logic                       pop_stall,
  output      res_t                       pop_data,
  output      logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && !pop_stall;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/label_region_boundary_mask_unit.sv =====
// Top level of the label region boundary mask: raster counters, line stores, window,
// classifier and result queue. Depends on lrbm_pkg, lrbm_ram, lrbm_window, lrbm_out_fifo.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  req      | req_valid/req_stall  | req_type, pixel_color
//  res      | res_valid/res_stall  | is_boundary, out_row, out_col, frame_last
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One transaction per clock sustained while req_stall is low; a pixel's result leaves after the
// pixel that completes its neighbourhood, passing through the line store read, the window
// register and the result queue. Line stores hold one read and one write per cycle;
// a same-column read straight after a write is forwarded. Reset needs no clearing pass.
// req_stall rises only when the four-entry result queue plus in-flight work is full.
`default_nettype none

module label_region_boundary_mask_unit
  import lrbm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output      logic                  req_stall,
  input  wire logic                  req_type,
  input  wire logic [IN_COLOR_W-1:0] pixel_color,
  output      logic                  res_valid,
  input  wire logic                  res_stall,
  output      logic                  is_boundary,
  output      logic [POS_W-1:0]      out_row,
  output      logic [POS_W-1:0]      out_col,
  output      logic                  frame_last,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int FCW = $clog2(OUT_DEPTH + 1);
  localparam int W_LAST_RST = (CFG_SIZE_RESET > MAX_WIDTH)  ? MAX_WIDTH - 1  : CFG_SIZE_RESET - 1;
  localparam int H_LAST_RST = (CFG_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT - 1 : CFG_SIZE_RESET - 1;

  // clamped size minus one
  function automatic logic [31:0] size_last(input logic [CFG_W-1:0] v, input int unsigned maxv);
    logic [31:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > maxv) begin
      r = maxv - 1;
    end else begin
      r = 32'(v) - 32'd1;
    end
    return r;
  endfunction

  // configuration and raster state
  logic [CW-1:0] w_last, w_last_next;
  logic [RW-1:0] h_last, h_last_next;
  logic [CW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [PW-1:0] pending, pending_next;
  logic [CW-1:0] drain_col, drain_col_next;
  logic [RW-1:0] drain_row, drain_row_next;

  // stage 1: line store data arrives
  logic                  s1_valid;
  logic                  s1_pix;
  logic                  s1_emit;
  logic                  s1_fwd;
  logic                  s1_last;
  logic [CW-1:0]         s1_col;
  logic [RW-1:0]         s1_qr;
  logic [CW-1:0]         s1_qc;
  logic [COLOR_BITS-1:0] s1_color;

  // stage 2: window holds the neighbourhood
  logic          s2_valid;
  logic          s2_drain;
  logic          s2_edge;
  logic          s2_last;
  logic [RW-1:0] s2_qr;
  logic [CW-1:0] s2_qc;

  logic [COLOR_BITS-1:0] fw_upper, fw_lower;
  logic [COLOR_BITS-1:0] ram_upper_q, ram_lower_q;
  logic [COLOR_BITS-1:0] up_rd, lo_rd;

  logic          req_fire, is_pix, pix_fire, drain_fire, cfg_hit;
  logic [CW-1:0] eff_col;
  logic [RW-1:0] eff_row;
  logic          col_end, row_end, emit, fwd_hit, s1_edge;
  logic [RW-1:0] qr;
  logic [CW-1:0] qc;
  logic          differs;
  logic [FCW-1:0] fifo_count;
  logic [FCW+1:0] busy;
  res_t          push_data, pop_data;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  assign busy      = (FCW+2)'(fifo_count) + (FCW+2)'(s1_valid) + (FCW+2)'(s2_valid);
  assign req_stall = (busy >= (FCW+2)'(OUT_DEPTH));
  assign req_fire  = req_valid && !req_stall;
  assign is_pix    = (req_type == REQ_PIXEL);
  assign pix_fire  = req_fire && is_pix;
  assign drain_fire = req_fire && !is_pix && (pending != '0);

  // a pixel arriving while results are pending starts a fresh frame
  assign eff_col = (pending != '0) ? '0 : in_col;
  assign eff_row = (pending != '0) ? '0 : in_row;
  assign col_end = (eff_col == w_last);
  assign row_end = (eff_row == h_last);
  assign emit    = (eff_row >= RW'(2)) || (eff_row == RW'(1) && eff_col != '0);
  assign qr      = (eff_col != '0) ? eff_row - RW'(1) : eff_row - RW'(2);
  assign qc      = (eff_col != '0) ? eff_col - CW'(1) : w_last;
  assign fwd_hit = s1_valid && s1_pix && (s1_col == eff_col);

  always_comb begin
    w_last_next    = w_last;
    h_last_next    = h_last;
    in_col_next    = in_col;
    in_row_next    = in_row;
    pending_next   = pending;
    drain_col_next = drain_col;
    drain_row_next = drain_row;
    if (cfg_hit) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_last_next = CW'(size_last(cfg_data, MAX_WIDTH));
      end else begin
        h_last_next = RW'(size_last(cfg_data, MAX_HEIGHT));
      end
      in_col_next  = '0;
      in_row_next  = '0;
      pending_next = '0;
    end else if (pix_fire) begin
      pending_next = '0;
      in_col_next  = col_end ? '0 : eff_col + CW'(1);
      in_row_next  = eff_row;
      if (col_end) begin
        in_row_next = row_end ? '0 : eff_row + RW'(1);
        if (row_end) begin
          // the last w+1 pixels (whole frame if smaller) await flush ticks
          pending_next = (h_last == '0) ? PW'(w_last) + PW'(1) : PW'(w_last) + PW'(2);
          if (h_last >= RW'(2) || (h_last == RW'(1) && w_last != '0)) begin
            drain_row_next = h_last - RW'(1);
            drain_col_next = w_last;
          end else begin
            drain_row_next = '0;
            drain_col_next = '0;
          end
        end
      end
    end else if (drain_fire) begin
      pending_next = pending - PW'(1);
      if (drain_col == w_last) begin
        drain_col_next = '0;
        drain_row_next = drain_row + RW'(1);
      end else begin
        drain_col_next = drain_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last   <= CW'(W_LAST_RST);
      h_last   <= RW'(H_LAST_RST);
      in_col   <= '0;
      in_row   <= '0;
      pending  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      w_last   <= w_last_next;
      h_last   <= h_last_next;
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      pending  <= pending_next;
      s1_valid <= pix_fire || drain_fire;
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    drain_col <= drain_col_next;
    drain_row <= drain_row_next;
    if (req_fire) begin
      s1_pix   <= is_pix;
      s1_emit  <= is_pix ? emit : 1'b1;
      s1_fwd   <= is_pix && fwd_hit;
      s1_last  <= !is_pix && (pending == PW'(1));
      s1_col   <= eff_col;
      s1_qr    <= is_pix ? qr : drain_row;
      s1_qc    <= is_pix ? qc : drain_col;
      s1_color <= pixel_color[COLOR_BITS-1:0];
    end
    if (s1_valid && s1_pix) begin
      fw_upper <= lo_rd;
      fw_lower <= s1_color;
    end
    if (s1_valid) begin
      s2_drain <= !s1_pix;
      s2_edge  <= s1_edge;
      s2_last  <= s1_last;
      s2_qr    <= s1_qr;
      s2_qc    <= s1_qc;
    end
  end

  assign up_rd   = s1_fwd ? fw_upper : ram_upper_q;
  assign lo_rd   = s1_fwd ? fw_lower : ram_lower_q;
  assign s1_edge = (s1_qr == '0) || (s1_qc == '0) || (s1_qr == h_last) || (s1_qc == w_last);

  lrbm_ram #(.WIDTH(COLOR_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid && s1_pix),
    .waddr (s1_col),
    .wdata (lo_rd),
    .re    (pix_fire),
    .raddr (eff_col),
    .rdata (ram_upper_q)
  );

  lrbm_ram #(.WIDTH(COLOR_BITS), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (s1_valid && s1_pix),
    .waddr (s1_col),
    .wdata (s1_color),
    .re    (pix_fire),
    .raddr (eff_col),
    .rdata (ram_lower_q)
  );

  lrbm_window #(.COLOR_BITS(COLOR_BITS)) u_window (
    .clk     (clk),
    .shift   (s1_valid && s1_pix),
    .up      (up_rd),
    .lo      (lo_rd),
    .color   (s1_color),
    .differs (differs)
  );

  always_comb begin
    push_data.is_boundary = s2_drain || s2_edge || differs;
    push_data.row         = POS_W'(s2_qr);
    push_data.col         = POS_W'(s2_qc);
    push_data.last        = s2_last;
  end

  lrbm_out_fifo #(.DEPTH(OUT_DEPTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .pop_valid (res_valid),
    .pop_stall (res_stall),
    .pop_data  (pop_data),
    .count     (fifo_count)
  );

  assign is_boundary = pop_data.is_boundary;
  assign out_row     = pop_data.row;
  assign out_col     = pop_data.col;
  assign frame_last  = pop_data.last;

endmodule

`default_nettype wire
